>>> rtl/cfc_pkg.sv
// Package for the CRC-16 frame checker: role and status codes, CRC constants,
// the byte-reversal and the byte-wide CRC-16/USB update functions.
// No dependencies.
package cfc_pkg;

   localparam int unsigned DEFAULT_MAX_FRAME = 256;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_XOROUT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;

   typedef enum logic [1:0] {
      ROLE_LEN     = 2'd0,
      ROLE_PAYLOAD = 2'd1,
      ROLE_CRC     = 2'd2,
      ROLE_PAD     = 2'd3
   } role_type;

   typedef enum logic [1:0] {
      ST_PENDING = 2'd0,
      ST_OK      = 2'd1,
      ST_CRC_ERR = 2'd2,
      ST_LEN_ERR = 2'd3
   } status_type;

   typedef struct packed {
      logic       step;
      logic       last;
      logic [7:0] data;
   } track_in_type;

   typedef struct packed {
      role_type   role;
      status_type status;
   } track_out_type;

   function automatic logic [7:0] reverse8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7 - i];
      end
      return r;
   endfunction

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> rtl/cfc_if.sv
// Valid/ready channel interfaces for the CRC-16 frame checker.
// Depends on nothing; payload widths follow the byte and result fields.
interface cfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] raw_byte;
   logic       frame_last;

   modport source (output valid, output raw_byte, output frame_last, input ready);
   modport sink   (input valid, input raw_byte, input frame_last, output ready);
endinterface

interface cfc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [1:0] byte_role;
   logic       frame_end;
   logic [1:0] frame_status;

   modport source (output valid, output data_byte, output byte_role, output frame_end,
                   output frame_status, input ready);
   modport sink   (input valid, input data_byte, input byte_role, input frame_end,
                   input frame_status, output ready);
endinterface

>>> rtl/cfc_frame_track.sv
// Frame tracker: byte position, length, running CRC and received CRC of the
// current frame; gives each decoded byte its role and the verdict. Uses cfc_pkg.
module cfc_frame_track #(
   parameter int unsigned MAX_FRAME = cfc_pkg::DEFAULT_MAX_FRAME
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfc_pkg::track_in_type trk_in,
   output cfc_pkg::track_out_type trk_out
);

   localparam int unsigned POS_W = $clog2(MAX_FRAME + 1);
   localparam int unsigned CMP_W = ((POS_W > 8) ? POS_W : 8) + 2;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       len_ff, len_in;
   logic [15:0]      crc_ff, crc_in;
   logic [15:0]      rcv_ff, rcv_in;
   logic             ovf_ff, ovf_in;

   logic [7:0]       len;
   logic             ovf;
   logic [CMP_W-1:0] p_ext, len_ext;
   logic [15:0]      crc_upd, rcv_upd;

   always_comb begin
      len     = (pos_ff == '0) ? trk_in.data : len_ff;
      ovf     = ovf_ff || (pos_ff >= POS_MAX);
      p_ext   = CMP_W'(pos_ff);
      len_ext = CMP_W'(len);

      priority if (pos_ff == '0)              trk_out.role = cfc_pkg::ROLE_LEN;
      else if (p_ext < len_ext)               trk_out.role = cfc_pkg::ROLE_PAYLOAD;
      else if (p_ext < len_ext + CMP_W'(2))   trk_out.role = cfc_pkg::ROLE_CRC;
      else                                    trk_out.role = cfc_pkg::ROLE_PAD;

      crc_upd = (p_ext < len_ext) ? cfc_pkg::crc16_byte(crc_ff, trk_in.data) : crc_ff;
      priority if (p_ext == len_ext)               rcv_upd = {rcv_ff[15:8], trk_in.data};
      else if (p_ext == len_ext + CMP_W'(1))       rcv_upd = {trk_in.data, rcv_ff[7:0]};
      else                                         rcv_upd = rcv_ff;

      trk_out.status = cfc_pkg::ST_PENDING;
      if (trk_in.last) begin
         priority if (ovf || len == 8'd0 || (len_ext + CMP_W'(2) > p_ext + CMP_W'(1)))
            trk_out.status = cfc_pkg::ST_LEN_ERR;
         else if ((crc_upd ^ cfc_pkg::CRC_XOROUT) == rcv_upd)
            trk_out.status = cfc_pkg::ST_OK;
         else
            trk_out.status = cfc_pkg::ST_CRC_ERR;
      end

      pos_in = pos_ff;
      len_in = len_ff;
      crc_in = crc_ff;
      rcv_in = rcv_ff;
      ovf_in = ovf_ff;
      if (trk_in.step) begin
         if (trk_in.last) begin
            pos_in = '0;
            len_in = 8'd0;
            crc_in = cfc_pkg::CRC_INIT;
            rcv_in = 16'd0;
            ovf_in = 1'b0;
         end else begin
            pos_in = (pos_ff < POS_MAX) ? pos_ff + POS_W'(1) : POS_MAX;
            len_in = len;
            crc_in = crc_upd;
            rcv_in = rcv_upd;
            ovf_in = ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         len_ff <= 8'd0;
         crc_ff <= cfc_pkg::CRC_INIT;
         rcv_ff <= 16'd0;
         ovf_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         len_ff <= len_in;
         crc_ff <= crc_in;
         rcv_ff <= rcv_in;
         ovf_ff <= ovf_in;
      end
   end

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_MAX)
      else $error("byte position beyond frame limit");

   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      trk_in.step && trk_in.last |=> pos_ff == '0 && crc_ff == cfc_pkg::CRC_INIT && !ovf_ff)
      else $error("frame state not cleared after last byte");

   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> pos_ff == POS_MAX)
      else $error("overflow set without saturated position");

endmodule

>>> rtl/crc16_frame_checker_unit.sv
// Top level of the CRC-16/USB length-prefixed frame checker.
// Uses cfc_pkg, the channel interfaces in cfc_if.sv and cfc_frame_track.
//
// Usage: received bytes enter on req_ch (raw_byte, frame_last), one per
// handshake. Each word is bit-reversed; the first decoded byte of a frame is
// its length L (counting itself), CRC-16/USB runs over bytes 0..L-1 and is
// compared with the little-endian CRC in bytes L and L+1; later bytes are
// padding. Every byte comes out on rsp_ch with its decoded value and role;
// the word that closes the frame also carries ok, crc error or length error.
// A word accepted on req_ch is held in the input register, passes the one-byte
// unrolled CRC step into the output register and is offered on rsp_ch from there.
// Throughput: one word per cycle while rsp_ch does not stall.
// Reset (synchronous) empties both registers and restarts frame tracking.
// When rsp_ch stalls, the result holds and one more word is taken into the
// input register; after that req_ch.ready drops until the result is taken.
module crc16_frame_checker_unit #(
   parameter int unsigned MAX_FRAME = cfc_pkg::DEFAULT_MAX_FRAME
) (
   input  logic            clock,
   input  logic            reset,
   cfc_req_if.sink         req_ch,
   cfc_rsp_if.source       rsp_ch
);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_raw_ff;
   logic       in_last_ff;

   logic       out_vld_ff, out_vld_in;
   logic [7:0] out_data_ff;
   logic [1:0] out_role_ff;
   logic       out_end_ff;
   logic [1:0] out_status_ff;

   logic       advance;
   logic       take;

   cfc_pkg::track_in_type  trk_in;
   cfc_pkg::track_out_type trk_out;

   always_comb begin
      advance       = in_vld_ff && (!out_vld_ff || rsp_ch.ready);
      req_ch.ready  = !in_vld_ff || advance;
      take          = req_ch.valid && req_ch.ready;
      in_vld_in     = take || (in_vld_ff && !advance);
      out_vld_in    = advance || (out_vld_ff && !rsp_ch.ready);
      trk_in.step   = advance;
      trk_in.last   = in_last_ff;
      trk_in.data   = cfc_pkg::reverse8(in_raw_ff);
   end

   cfc_frame_track #(
      .MAX_FRAME(MAX_FRAME)
   ) u_track (
      .clock  (clock),
      .reset  (reset),
      .trk_in (trk_in),
      .trk_out(trk_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_raw_ff  <= req_ch.raw_byte;
         in_last_ff <= req_ch.frame_last;
      end
      if (advance) begin
         out_data_ff   <= trk_in.data;
         out_role_ff   <= trk_out.role;
         out_end_ff    <= in_last_ff;
         out_status_ff <= trk_out.status;
      end
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.data_byte    = out_data_ff;
   assign rsp_ch.byte_role    = out_role_ff;
   assign rsp_ch.frame_end    = out_end_ff;
   assign rsp_ch.frame_status = out_status_ff;

   a_pending_mid_frame: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !out_end_ff |-> out_status_ff == cfc_pkg::ST_PENDING)
      else $error("verdict on a byte that does not close the frame");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff && $stable(in_raw_ff) && $stable(in_last_ff))
      else $error("input register lost a word while blocked");

   a_result_made: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_vld_ff)
      else $error("advanced word did not reach the result register");

endmodule

>>> dv/crc16_frame_checker_unit_chk.sv
// Checker for the CRC-16 frame checker: predicts each result word from the accepted
// input words and compares it field by field with what the block returns.
// Depends on cfc_pkg and the channel interfaces in cfc_if.sv.
module crc16_frame_checker_unit_chk #(
   parameter int unsigned MAX_FRAME = cfc_pkg::DEFAULT_MAX_FRAME
) (
   input  logic clock,
   input  logic reset,
   cfc_req_if   req_ch,
   cfc_rsp_if   rsp_ch,
   output int   fail_count,
   output int   words_pending,
   output int   good_frames,
   output int   crc_bad_frames,
   output int   len_bad_frames
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0]           data;
      cfc_pkg::role_type    role;
      logic                 last;
      cfc_pkg::status_type  status;
   } decoded_word_type;

   decoded_word_type decoded_q[$];

   int unsigned position;
   logic [7:0]  length_byte;
   logic [15:0] crc_run;
   logic [15:0] crc_seen;
   logic        overflow;
   int          mismatches = 0;
   int          n_good = 0;
   int          n_crc_bad = 0;
   int          n_len_bad = 0;

   assign fail_count     = mismatches;
   assign good_frames    = n_good;
   assign crc_bad_frames = n_crc_bad;
   assign len_bad_frames = n_len_bad;

   function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ b[i];
         r = r >> 1;
         if (fb) r = r ^ cfc_pkg::CRC_POLY;
      end
      return r;
   endfunction

   task automatic clear_frame();
      position    = 0;
      length_byte = 8'd0;
      crc_run     = cfc_pkg::CRC_INIT;
      crc_seen    = 16'd0;
      overflow    = 1'b0;
   endtask

   task automatic predict_word(input logic [7:0] raw, input logic last);
      decoded_word_type w;
      logic [7:0]       d;
      int unsigned      lim;
      logic             ovf_now;
      d = {<<{raw}};
      ovf_now = overflow || (position >= MAX_FRAME);
      if (position == 0) length_byte = d;
      lim = length_byte;
      if (position == 0) w.role = cfc_pkg::ROLE_LEN;
      else if (position < lim) w.role = cfc_pkg::ROLE_PAYLOAD;
      else if (position < lim + 2) w.role = cfc_pkg::ROLE_CRC;
      else w.role = cfc_pkg::ROLE_PAD;
      if (position < lim) crc_run = crc_update(crc_run, d);
      if (position == lim) crc_seen[7:0] = d;
      else if (position == lim + 1) crc_seen[15:8] = d;
      w.status = cfc_pkg::ST_PENDING;
      if (last) begin
         if (ovf_now || lim == 0 || lim + 2 > position + 1) begin
            w.status = cfc_pkg::ST_LEN_ERR;
            n_len_bad++;
         end else if ((crc_run ^ cfc_pkg::CRC_XOROUT) == crc_seen) begin
            w.status = cfc_pkg::ST_OK;
            n_good++;
         end else begin
            w.status = cfc_pkg::ST_CRC_ERR;
            n_crc_bad++;
         end
         clear_frame();
      end else begin
         overflow = ovf_now;
         position = (position < MAX_FRAME) ? position + 1 : MAX_FRAME;
      end
      w.data = d;
      w.last = last;
      decoded_q.push_back(w);
   endtask

   task automatic check_word();
      decoded_word_type w;
      if (decoded_q.size() == 0) begin
         $error("unexpected result word: data_byte %02h", rsp_ch.data_byte);
         mismatches++;
      end else begin
         w = decoded_q.pop_front();
         if (rsp_ch.data_byte !== w.data) begin
            $error("data_byte: expected %02h, got %02h", w.data, rsp_ch.data_byte);
            mismatches++;
         end
         if (rsp_ch.byte_role !== w.role) begin
            $error("byte_role: expected %0d, got %0d", w.role, rsp_ch.byte_role);
            mismatches++;
         end
         if (rsp_ch.frame_end !== w.last) begin
            $error("frame_end: expected %0d, got %0d", w.last, rsp_ch.frame_end);
            mismatches++;
         end
         if (rsp_ch.frame_status !== w.status) begin
            $error("frame_status: expected %0d, got %0d", w.status, rsp_ch.frame_status);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         decoded_q.delete();
         clear_frame();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_word();
         if (req_ch.valid && req_ch.ready) predict_word(req_ch.raw_byte, req_ch.frame_last);
      end
      words_pending <= decoded_q.size();
   end

endmodule

>>> dv/crc16_frame_checker_unit_tb.sv
// Testbench top for crc16_frame_checker_unit: builds length-prefixed frames with
// good, corrupted, short, empty and oversize layouts and drives them with random gaps.
// Depends on cfc_pkg, cfc_if.sv, the block and crc16_frame_checker_unit_chk.
module crc16_frame_checker_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FRAME_CAP   = cfc_pkg::DEFAULT_MAX_FRAME;
   localparam int          ITEMS       = 1850;
   localparam int          QUIET_LIMIT = 1000;

   logic clock;
   logic reset;

   cfc_req_if req_ch();
   cfc_rsp_if rsp_ch();

   int fail_count;
   int words_pending;
   int good_frames;
   int crc_bad_frames;
   int len_bad_frames;

   logic [7:0] frame_bytes[$];
   int         words_sent = 0;
   int         frames_sent = 0;
   int         gap_odds = 0;
   bit         calm = 1'b0;
   int         quiet = 0;

   crc16_frame_checker_unit #(.MAX_FRAME(FRAME_CAP)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   crc16_frame_checker_unit_chk #(.MAX_FRAME(FRAME_CAP)) chk (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .fail_count     (fail_count),
      .words_pending  (words_pending),
      .good_frames    (good_frames),
      .crc_bad_frames (crc_bad_frames),
      .len_bad_frames (len_bad_frames)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [15:0] fold_crc(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ cfc_pkg::CRC_POLY) : (c >> 1);
      return c;
   endfunction

   task automatic seal_frame();
      logic [15:0] c;
      c = cfc_pkg::CRC_INIT;
      foreach (frame_bytes[i]) c = fold_crc(c, frame_bytes[i]);
      c = c ^ cfc_pkg::CRC_XOROUT;
      frame_bytes.push_back(c[7:0]);
      frame_bytes.push_back(c[15:8]);
   endtask

   task automatic build_good(input int len, input int pad);
      frame_bytes.delete();
      frame_bytes.push_back(8'(len));
      repeat (len - 1) frame_bytes.push_back(8'($urandom));
      seal_frame();
      repeat (pad) frame_bytes.push_back(8'($urandom));
   endtask

   task automatic send_word(input logic [7:0] value, input logic last);
      if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
         req_ch.valid      <= 1'b0;
         req_ch.raw_byte   <= 8'($urandom);
         req_ch.frame_last <= 1'($urandom);
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.raw_byte   <= {<<{value}};
      req_ch.frame_last <= last;
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
      words_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_word(frame_bytes[i], i == frame_bytes.size() - 1);
      frames_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (words_pending != 0);
      @(posedge clock);
   endtask

   // hold ready in random bursts, with long open stretches mixed in
   initial begin
      int hold;
      bit want;
      hold = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset || calm) begin
            rsp_ch.ready <= 1'b1;
         end else if (hold != 0) begin
            hold--;
         end else begin
            want = ($urandom_range(0, 2) != 0);
            if (want && $urandom_range(0, 3) == 0) hold = $urandom_range(1, 60) - 1;
            else hold = $urandom_range(1, 9) - 1;
            rsp_ch.ready <= want;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("crc16_frame_checker_unit_tb NOT OK");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      int  len;
      int  kind;
      int  cut;
      bit  big_done;
      big_done          = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.raw_byte   = 8'd0;
      req_ch.frame_last = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      frame_bytes = '{8'd1};
      seal_frame();
      send_frame();
      frame_bytes = '{8'd3, 8'h00, 8'hFF};
      seal_frame();
      frame_bytes.push_back(8'hFF);
      send_frame();
      frame_bytes = '{8'd3, 8'hFF, 8'h00};
      seal_frame();
      frame_bytes[4] ^= 8'h80;
      send_frame();
      frame_bytes = '{8'd0, 8'hA5};
      send_frame();
      frame_bytes = '{8'h00};
      send_frame();
      frame_bytes = '{8'hFF};
      send_frame();
      frame_bytes = '{8'd4, 8'h11, 8'h22, 8'h33};
      seal_frame();
      void'(frame_bytes.pop_back());
      send_frame();
      drain();

      while (words_sent < ITEMS) begin
         if (words_sent >= ITEMS - 150) calm = 1'b1;
         case ($urandom_range(0, 2))
            0: gap_odds = 0;
            1: gap_odds = 3;
            default: gap_odds = 6;
         endcase
         if (!big_done && words_sent >= ITEMS / 3) begin
            big_done = 1'b1;
            build_good(FRAME_CAP - 2, 0);
            send_frame();
            build_good(255, 0);
            send_frame();
            build_good($urandom_range(1, 20), 0);
            repeat (FRAME_CAP + $urandom_range(2, 6) - frame_bytes.size())
               frame_bytes.push_back(8'($urandom));
            send_frame();
         end
         kind = $urandom_range(0, 99);
         len = ($urandom_range(0, 6) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
         if (kind < 70) begin
            build_good(len, $urandom_range(0, 3));
         end else if (kind < 80) begin
            build_good(len, $urandom_range(0, 2));
            frame_bytes[$urandom_range(1, len + 1)] ^= 8'($urandom_range(1, 255));
         end else if (kind < 88) begin
            build_good(len, 0);
            cut = $urandom_range(1, len + 1);
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
         end else if (kind < 93) begin
            frame_bytes = '{8'd0};
            repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
         end else begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
         end
         send_frame();
         if (!calm && $urandom_range(0, 24) == 0) drain();
      end

      drain();
      repeat (4) @(posedge clock);
      $display("covered %0d words in %0d frames: %0d good, %0d crc errors, %0d length errors",
               words_sent, frames_sent, good_frames, crc_bad_frames, len_bad_frames);
      if (fail_count == 0 && words_pending == 0) begin
         $display("crc16_frame_checker_unit_tb OK");
      end else begin
         $display("crc16_frame_checker_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
